@@ rtl/core/cjtlp_pkg.sv @@
// Shared types and constants of the joint target line parser.
`timescale 1ns / 1ps
package cjtlp_pkg;

  localparam int CHAR_W  = 8;
  localparam int ACCUM_W = 16;
  localparam int LIMIT_W = 15;
  localparam int KIND_W  = 3;
  localparam int KW_W    = 3;
  localparam int OUT_W   = 48;
  localparam int TARGET_SLOTS = 3;

  localparam logic [KIND_W-1:0] KIND_NEWLINE = 3'd0;
  localparam logic [KIND_W-1:0] KIND_COMMA   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DIGIT   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_BLANK   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_PLUS    = 3'd4;
  localparam logic [KIND_W-1:0] KIND_MINUS   = 3'd5;
  localparam logic [KIND_W-1:0] KIND_OTHER   = 3'd6;

  localparam logic [1:0] PHASE_SKIP = 2'd0;
  localparam logic [1:0] PHASE_READ = 2'd1;
  localparam logic [1:0] PHASE_STOP = 2'd2;

  localparam logic [KW_W-1:0] KW_MATCHED = 3'd4;
  localparam logic [KW_W-1:0] KW_FAIL    = 3'd5;

  localparam logic [1:0] SLOT_DONE = 2'd3;

  localparam logic [1:0] REG_LIMIT_A = 2'd0;
  localparam logic [1:0] REG_LIMIT_B = 2'd1;
  localparam logic [1:0] REG_LIMIT_C = 2'd2;

  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_COMMA = 8'h2C;
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_VT    = 8'h0B;
  localparam logic [CHAR_W-1:0] CHAR_FF    = 8'h0C;

  localparam logic [3:0][CHAR_W-1:0] KEYWORD = {8'h4B, 8'h53, 8'h41, 8'h54};

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [3:0]        digit;
    logic [3:0]        kw_hit;
  } q_item_t;

endpackage

@@ rtl/core/csv_joint_target_line_parser_core.sv @@
// Top level of the joint target line parser.
`timescale 1ns / 1ps
// The block reads a command line one ASCII byte per transfer on the slave
// stream and produces one result transfer on the master stream for every
// newline. Carriage returns are dropped. A line reading TASK in any case sets
// task_start and keeps the joint targets; any other line is read as up to
// three comma-separated decimal integers, each clamped to 0..limit and kept
// as the new target of its joint. The user must write limits on the
// configuration port only while no line is in flight; the block itself does
// not enforce this. A byte is taken every cycle while the queue is not full.
// Accepted bytes are classified at once and written into a short queue; the
// parser behind it handles one byte per cycle but holds a newline while an
// unaccepted result is pending, and each newline it takes sets m_tvalid.
// When the receiver stalls, the result register holds, the parser
// stops on the next newline, the queue fills, and only then does s_tready
// drop. Reset clears the targets, the line state and the queue, and sets all
// limits to 32767.
module csv_joint_target_line_parser_core #(
  parameter int JOINT_COUNT = 3,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_index,
  input  logic [cjtlp_pkg::LIMIT_W-1:0]  cfg_data,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [cjtlp_pkg::CHAR_W-1:0]   s_tdata,  // [7:0] char_in
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [0] task_start, [15:1] target_a, [30:16] target_b, [45:31] target_c,
  // [47:46] zero
  output logic [cjtlp_pkg::OUT_W-1:0]    m_tdata
);
  import cjtlp_pkg::*;

  q_item_t push_item;
  q_item_t head;
  logic    push;
  logic    full;
  logic    pop;
  logic    not_empty;

  cjtlp_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_full   (full),
    .q_push   (push),
    .q_item   (push_item)
  );

  cjtlp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head)
  );

  cjtlp_back #(
    .JOINT_COUNT (JOINT_COUNT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (not_empty),
    .q_head    (head),
    .q_pop     (pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

@@ rtl/core/cjtlp_front.sv @@
// Front end: classifies each received byte and drops carriage returns.
`timescale 1ns / 1ps
module cjtlp_front (
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [cjtlp_pkg::CHAR_W-1:0]   s_tdata,  // [7:0] char_in
  input  logic                           q_full,
  output logic                           q_push,
  output cjtlp_pkg::q_item_t             q_item
);
  import cjtlp_pkg::*;

  logic [CHAR_W-1:0] upper;

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full && (s_tdata != CHAR_CR);
  assign upper    = (s_tdata >= 8'h61 && s_tdata <= 8'h7A) ? s_tdata - 8'd32 : s_tdata;

  always_comb begin
    q_item.digit = s_tdata[3:0];
    for (int k = 0; k < 4; k++) begin
      q_item.kw_hit[k] = (upper == KEYWORD[k]);
    end
    if (s_tdata == CHAR_LF) begin
      q_item.kind = KIND_NEWLINE;
    end else if (s_tdata == CHAR_COMMA) begin
      q_item.kind = KIND_COMMA;
    end else if (s_tdata >= 8'h30 && s_tdata <= 8'h39) begin
      q_item.kind = KIND_DIGIT;
    end else if (s_tdata == CHAR_SPACE || s_tdata == CHAR_TAB ||
                 s_tdata == CHAR_VT || s_tdata == CHAR_FF) begin
      q_item.kind = KIND_BLANK;
    end else if (s_tdata == CHAR_PLUS) begin
      q_item.kind = KIND_PLUS;
    end else if (s_tdata == CHAR_MINUS) begin
      q_item.kind = KIND_MINUS;
    end else begin
      q_item.kind = KIND_OTHER;
    end
  end

endmodule

@@ rtl/core/cjtlp_queue.sv @@
// Short queue of classified bytes between the front and back ends.
`timescale 1ns / 1ps
module cjtlp_queue #(
  parameter int DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  cjtlp_pkg::q_item_t   push_item,
  output logic                 full,
  input  logic                 pop,
  output logic                 not_empty,
  output cjtlp_pkg::q_item_t   head
);
  import cjtlp_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  q_item_t         entries [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/cjtlp_back.sv @@
// Back end: field parser, keyword match, clamping and the result register.
`timescale 1ns / 1ps
module cjtlp_back #(
  parameter int JOINT_COUNT = 3
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_index,
  input  logic [cjtlp_pkg::LIMIT_W-1:0]  cfg_data,
  input  logic                           q_valid,
  input  cjtlp_pkg::q_item_t             q_head,
  output logic                           q_pop,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [cjtlp_pkg::OUT_W-1:0]    m_tdata
);
  import cjtlp_pkg::*;

  logic [LIMIT_W-1:0] limits [TARGET_SLOTS];
  logic [LIMIT_W-1:0] targets [TARGET_SLOTS];
  logic [ACCUM_W-1:0] line_values [TARGET_SLOTS];
  logic [1:0]         field_slot;
  logic [ACCUM_W-1:0] digit_accum;
  logic               value_negative;
  logic [1:0]         token_phase;
  logic [KW_W-1:0]    keyword_progress;
  logic               task_flag;

  logic               load_ok;
  logic               is_newline;
  logic [ACCUM_W-1:0] store_value;
  logic [19:0]        accum_sum;
  logic [ACCUM_W-1:0] accum_next;
  logic [ACCUM_W-1:0] final_values [TARGET_SLOTS];

  assign load_ok     = !m_tvalid || m_tready;
  assign is_newline  = (q_head.kind == KIND_NEWLINE);
  assign q_pop       = q_valid && (!is_newline || load_ok);
  assign store_value = value_negative ? '0 : digit_accum;
  assign accum_sum   = {1'b0, digit_accum, 3'b0} + {3'b0, digit_accum, 1'b0}
                     + {16'b0, q_head.digit};
  assign accum_next  = (accum_sum > 20'h0FFFF) ? {ACCUM_W{1'b1}} : accum_sum[ACCUM_W-1:0];
  assign m_tdata     = {2'b00, targets[2], targets[1], targets[0], task_flag};

  always_comb begin
    for (int i = 0; i < TARGET_SLOTS; i++) begin
      final_values[i] = (field_slot == 2'(i)) ? store_value : line_values[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TARGET_SLOTS; i++) begin
        limits[i] <= {LIMIT_W{1'b1}};
      end
    end else if (cfg_we && cfg_index <= REG_LIMIT_C) begin
      limits[cfg_index] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid         <= 1'b0;
      task_flag        <= 1'b0;
      field_slot       <= '0;
      digit_accum      <= '0;
      value_negative   <= 1'b0;
      token_phase      <= PHASE_SKIP;
      keyword_progress <= '0;
      for (int i = 0; i < TARGET_SLOTS; i++) begin
        line_values[i] <= '0;
        targets[i]     <= '0;
      end
    end else begin
      if (q_pop && is_newline) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (q_pop) begin
        if (is_newline) begin
          task_flag <= (keyword_progress == KW_MATCHED);
          if (keyword_progress != KW_MATCHED) begin
            for (int i = 0; i < TARGET_SLOTS; i++) begin
              if (i < JOINT_COUNT) begin
                targets[i] <= (final_values[i] > {1'b0, limits[i]}) ? limits[i]
                            : final_values[i][LIMIT_W-1:0];
              end
            end
          end
          field_slot       <= '0;
          keyword_progress <= '0;
          digit_accum      <= '0;
          value_negative   <= 1'b0;
          token_phase      <= PHASE_SKIP;
          for (int i = 0; i < TARGET_SLOTS; i++) begin
            line_values[i] <= '0;
          end
        end else begin
          if (keyword_progress < KW_MATCHED && q_head.kw_hit[keyword_progress[1:0]]) begin
            keyword_progress <= keyword_progress + 1'b1;
          end else begin
            keyword_progress <= KW_FAIL;
          end
          if (field_slot != SLOT_DONE) begin
            unique case (q_head.kind) inside
              KIND_COMMA: begin
                line_values[field_slot] <= store_value;
                field_slot              <= field_slot + 1'b1;
                digit_accum             <= '0;
                value_negative          <= 1'b0;
                token_phase             <= PHASE_SKIP;
              end
              KIND_DIGIT: begin
                if (token_phase != PHASE_STOP) begin
                  digit_accum <= accum_next;
                  token_phase <= PHASE_READ;
                end
              end
              KIND_BLANK: begin
                if (token_phase != PHASE_SKIP) begin
                  token_phase <= PHASE_STOP;
                end
              end
              KIND_PLUS, KIND_MINUS: begin
                if (token_phase == PHASE_SKIP) begin
                  value_negative <= (q_head.kind == KIND_MINUS);
                  token_phase    <= PHASE_READ;
                end else begin
                  token_phase <= PHASE_STOP;
                end
              end
              default: begin
                token_phase <= PHASE_STOP;
              end
            endcase
          end
        end
      end
    end
  end

endmodule

@@ tb/tb_csv_joint_target_line_parser_core.sv @@
// Self-checking testbench of the joint target line parser core.
`timescale 1ns / 1ps
module tb_csv_joint_target_line_parser_core;
  import cjtlp_pkg::*;

  localparam int DRAIN_CYCLES = 12;
  localparam int PHASE_BYTES  = 210;
  localparam int MAX_REPORTS  = 10;

  class target_scoreboard;
    logic [LIMIT_W-1:0] limits [TARGET_SLOTS];
    logic [LIMIT_W-1:0] targets [TARGET_SLOTS];
    logic [ACCUM_W-1:0] line_vals [TARGET_SLOTS];
    logic [1:0]         slot;
    logic [ACCUM_W-1:0] accum;
    logic               neg;
    logic [1:0]         tok;
    logic [KW_W-1:0]    kw;
    logic [OUT_W-1:0]   expected_targets [$];
    int                 failures;

    function new();
      foreach (limits[i]) begin
        limits[i] = '1;
        targets[i] = '0;
      end
      failures = 0;
      clear_line();
    endfunction

    function void set_limits(logic [LIMIT_W-1:0] la, logic [LIMIT_W-1:0] lb,
                             logic [LIMIT_W-1:0] lc);
      limits[0] = la;
      limits[1] = lb;
      limits[2] = lc;
    endfunction

    function void clear_field();
      accum = '0;
      neg = 1'b0;
      tok = PHASE_SKIP;
    endfunction

    function void clear_line();
      slot = '0;
      kw = '0;
      foreach (line_vals[i]) line_vals[i] = '0;
      clear_field();
    endfunction

    function void store_field();
      if (slot != SLOT_DONE) begin
        line_vals[slot] = neg ? '0 : accum;
        slot = slot + 2'd1;
      end
      clear_field();
    endfunction

    function void take_byte(logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] up;
      logic [31:0]       next;
      logic              start_flag;
      if (c == CHAR_CR) return;
      if (c == CHAR_LF) begin
        start_flag = (kw == KW_MATCHED);
        if (!start_flag) begin
          store_field();
          foreach (targets[i])
            targets[i] = (line_vals[i] > limits[i]) ? limits[i] : line_vals[i][LIMIT_W-1:0];
        end
        expected_targets.push_back({2'b00, targets[2], targets[1], targets[0], start_flag});
        clear_line();
        return;
      end
      up = (c >= "a" && c <= "z") ? c - 8'd32 : c;
      if (kw < KW_MATCHED && up == KEYWORD[kw[1:0]]) kw = kw + 1'b1;
      else kw = KW_FAIL;
      if (slot == SLOT_DONE) return;
      if (c == CHAR_COMMA) begin
        store_field();
        return;
      end
      if (c >= "0" && c <= "9") begin
        if (tok != PHASE_STOP) begin
          next = accum * 32'd10 + (c - "0");
          accum = (next > 32'hFFFF) ? '1 : next[ACCUM_W-1:0];
          tok = PHASE_READ;
        end
      end else if (tok == PHASE_SKIP) begin
        if (c == CHAR_PLUS || c == CHAR_MINUS) begin
          neg = (c == CHAR_MINUS);
          tok = PHASE_READ;
        end else if (!(c inside {CHAR_SPACE, CHAR_TAB, CHAR_VT, CHAR_FF})) begin
          tok = PHASE_STOP;
        end
      end else begin
        tok = PHASE_STOP;
      end
    endfunction

    function void check_targets(logic [OUT_W-1:0] got);
      logic [OUT_W-1:0] want;
      if (expected_targets.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("Unexpected result: task_start=%0d a=%0d b=%0d c=%0d",
                   got[0], got[15:1], got[30:16], got[45:31]);
        return;
      end
      want = expected_targets.pop_front();
      if (got[0] !== want[0] || got[15:1] !== want[15:1] ||
          got[30:16] !== want[30:16] || got[45:31] !== want[45:31]) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("Mismatch: expected task_start=%0d a=%0d b=%0d c=%0d, got %0d %0d %0d %0d",
                   want[0], want[15:1], want[30:16], want[45:31],
                   got[0], got[15:1], got[30:16], got[45:31]);
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [LIMIT_W-1:0] cfg_data = '0;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [CHAR_W-1:0]  s_tdata = '0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [OUT_W-1:0]   m_tdata;

  target_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int bytes_sent = 0;

  csv_joint_target_line_parser_core uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_targets(m_tdata);
      if (s_tvalid && s_tready) sb.take_byte(s_tdata);
    end
  end

  task automatic send_byte(input logic [CHAR_W-1:0] ch);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= ch;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_random_line();
    int kind, n, len, i;
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      for (i = 0; i < 4; i++) send_byte(KEYWORD[i] | ($urandom_range(0, 1) ? 8'h20 : 8'h00));
    end else if (kind < 16) begin
      n = $urandom_range(0, 2);
      if (n == 2) send_byte(CHAR_SPACE);
      len = (n == 0) ? $urandom_range(1, 3) : 4;
      for (i = 0; i < len; i++) send_byte(KEYWORD[i]);
      if (n == 1) send_byte(CHAR_W'($urandom_range(33, 126)));
    end else if (kind < 26) begin
      repeat ($urandom_range(1, 8)) send_byte(CHAR_W'($urandom_range(0, 255)));
    end else begin
      n = $urandom_range(0, 5);
      for (i = 0; i < n; i++) begin
        if (i > 0) send_byte(CHAR_COMMA);
        repeat ($urandom_range(0, 2)) begin
          case ($urandom_range(0, 3))
            0: send_byte(CHAR_SPACE);
            1: send_byte(CHAR_TAB);
            2: send_byte(CHAR_VT);
            default: send_byte(CHAR_FF);
          endcase
        end
        case ($urandom_range(0, 3))
          0: send_byte(CHAR_PLUS);
          1: send_byte(CHAR_MINUS);
          default: ;
        endcase
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 8) : $urandom_range(0, 5);
        repeat (len) send_byte(CHAR_W'("0" + $urandom_range(0, 9)));
        if ($urandom_range(0, 7) == 0) send_byte(CHAR_W'($urandom_range(32, 126)));
      end
    end
    if ($urandom_range(0, 3) == 0) send_byte(CHAR_CR);
    send_byte(CHAR_LF);
  endtask

  task automatic write_limits(input logic [LIMIT_W-1:0] la, input logic [LIMIT_W-1:0] lb,
                              input logic [LIMIT_W-1:0] lc);
    cfg_we <= 1'b1;
    cfg_index <= REG_LIMIT_A;
    cfg_data <= la;
    @(posedge clk);
    cfg_index <= REG_LIMIT_B;
    cfg_data <= lb;
    @(posedge clk);
    cfg_index <= REG_LIMIT_C;
    cfg_data <= lc;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_limits(la, lb, lc);
  endtask

  task automatic wait_drain();
    s_tvalid <= 1'b0;
    while (sb.expected_targets.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int ph, start;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_text("TaSk\n");
    send_text("99999,-7,\v+12a3\r\n");
    send_text("\n");
    send_text("1,2,3,4\n");
    wait_drain();
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          write_limits('1, '1, '1);
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          write_limits('0, 15'd1000, '1);
          send_idle_pct = 75;
          recv_stall_pct = 0;
        end
        2: begin
          write_limits(LIMIT_W'($urandom_range(0, 32767)),
                       LIMIT_W'($urandom_range(0, 32767)),
                       LIMIT_W'($urandom_range(0, 32767)));
          send_idle_pct = 0;
          recv_stall_pct = 75;
        end
        default: begin
          write_limits(15'd12345, '0, 15'd9);
          send_idle_pct = 26;
          recv_stall_pct = 26;
        end
      endcase
      start = bytes_sent;
      while (bytes_sent - start < PHASE_BYTES) send_random_line();
      wait_drain();
    end
    if (sb.failures == 0 && sb.expected_targets.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/cjtlp_pkg.sv
rtl/core/cjtlp_front.sv
rtl/core/cjtlp_queue.sv
rtl/core/cjtlp_back.sv
rtl/core/csv_joint_target_line_parser_core.sv
tb/tb_csv_joint_target_line_parser_core.sv
